FILE: src/frame_average_rank_tone_map_assert.svh
// Assertion macros shared by the checker of the frame average rank tone map block.
`ifndef FRAME_AVERAGE_RANK_TONE_MAP_ASSERT_SVH
`define FRAME_AVERAGE_RANK_TONE_MAP_ASSERT_SVH

// Implication into the next cycle, disabled while reset is active.
`define FARTM_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |=> (rhs)) \
        else $error("assertion failed");

// Implication in the same cycle, disabled while reset is active.
`define FARTM_ASSERT_SAME(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Implication into the next cycle that also holds across reset.
`define FARTM_ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
    label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

FILE: src/fartm_pkg.sv
// Shared codes, datapath operations and controller/datapath interface structs.
`default_nettype none
package fartm_pkg;

    localparam logic [1:0] REQ_ACC  = 2'd0;
    localparam logic [1:0] REQ_FIN  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;
    localparam logic [1:0] REQ_CLR  = 2'd3;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FIN   = 1'b1;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLR_ALL,
        OP_ACC_RD,
        OP_ACC_WR,
        OP_FIN_CLR,
        OP_FIN_MARK,
        OP_FIN_RANK,
        OP_RD_SUM,
        OP_RD_LUM,
        OP_RD_K,
        OP_MUL_RR,
        OP_MUL_GG,
        OP_MUL_BB,
        OP_MUL_NN,
        OP_MUL_BSQ,
        OP_MUL_CK,
        OP_MUL_TT,
        OP_Q_INIT,
        OP_Q_STEP,
        OP_Q_STORE,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        logic   load;
        logic   walk_clr;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic mul_done;
        logic q_last;
        logic last_ch;
        logic rd_zero;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: src/fartm_mul.sv
// Bit-serial shift and add multiplier shared by all products of a read.
`default_nettype none
module fartm_mul
    import fartm_pkg::*;
#(
    parameter int OW = 41
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [OW-1:0]   op_a,
    input  wire logic [OW-1:0]   op_b,
    output logic                 done,
    output logic [2*OW-1:0]      prod
);
    localparam int PW = 2 * OW;

    logic [PW-1:0] a_reg;
    logic [OW-1:0] b_reg;
    logic [PW-1:0] acc_reg;
    logic          busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            a_reg    <= PW'(op_a);
            b_reg    <= op_b;
            acc_reg  <= '0;
        end else if (busy_reg) begin
            if (b_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                if (b_reg[0]) begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg <= a_reg << 1;
                b_reg <= b_reg >> 1;
            end
        end
    end

    assign done = busy_reg && (b_reg == '0);
    assign prod = acc_reg;

endmodule
`default_nettype wire

FILE: src/fartm_datapath.sv
// Datapath: sum, presence and rank memories, walk counter and read arithmetic.
`default_nettype none
module fartm_datapath
    import fartm_pkg::*;
#(
    parameter int IMG_WIDTH  = 160,
    parameter int IMG_HEIGHT = 210,
    parameter int SUM_BITS   = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         stat,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [15:0] s_pixel_index,
    input  wire logic [7:0]  s_in_red,
    input  wire logic [7:0]  s_in_green,
    input  wire logic [7:0]  s_in_blue,
    output logic             res_kind,
    output logic [7:0]       res_red,
    output logic [7:0]       res_green,
    output logic [7:0]       res_blue,
    output logic [15:0]      res_distinct
);
    localparam int SB  = SUM_BITS;
    localparam int NP  = IMG_WIDTH * IMG_HEIGHT;
    localparam int LS  = 1 << SB;
    localparam int CL  = (NP > LS) ? NP : LS;
    localparam int PAW = (NP > 1) ? $clog2(NP) : 1;
    localparam int XW  = (PAW > 16) ? PAW : 16;
    localparam int CW  = SB + 1;
    localparam int IW  = ($clog2(CL + 1) > CW) ? $clog2(CL + 1) : CW;
    localparam int OW  = 2 * SB + 9;
    localparam int PW  = 2 * OW;
    localparam int WW  = PW + 2;

    logic [3*SB-1:0] sums_mem [NP];
    logic            pres_mem [LS];
    logic [CW-1:0]   rank_mem [LS];

    logic [1:0]      req_reg;
    logic [PAW-1:0]  addr_reg;
    logic            in_range_reg;
    logic [7:0]      smp_r_reg, smp_g_reg, smp_b_reg;
    logic [IW-1:0]   idx_reg;
    logic            pipe_v_reg;
    logic [SB-1:0]   rank_wa_reg;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   distinct_reg;
    logic [3*SB-1:0] rd_sum_reg;
    logic            pres_q_reg;
    logic [CW-1:0]   rank_q_reg;
    logic [SB-1:0]   r_reg, g_reg, b_reg;
    logic [CW-1:0]   k_reg;
    logic            zero_reg;
    logic [OW-1:0]   sq_reg, n2_reg, t_reg;
    logic [PW-1:0]   bv_reg, av_reg;
    logic [WW-1:0]   p_reg, e_reg, f_reg;
    logic [2:0]      bit_reg;
    logic [7:0]      q_reg;
    logic [7:0]      q_ch_reg [3];
    logic [1:0]      ch_reg;
    dp_op_t          mul_dest_reg;

    logic [XW-1:0]   idx_x;
    logic [IW-1:0]   limit;
    logic            walk_go;
    logic            mul_start, mul_done;
    logic [OW-1:0]   mul_a, mul_b;
    logic [PW-1:0]   mul_p;
    logic [SB-1:0]   c_sel;
    logic [WW-1:0]   cand;
    logic            take;
    logic            sw_en, pw_en, pw_data, rw_en;
    logic [PAW-1:0]  sw_addr, sr_addr;
    logic [3*SB-1:0] sw_data;
    logic [SB-1:0]   pw_addr;
    logic [SB:0]     sat_r, sat_g, sat_b;
    logic [SB-1:0]   rd_lum;
    logic [OW-1:0]   ck_trunc;

    function automatic logic [SB-1:0] lum_of(input logic [3*SB-1:0] w);
        logic [SB-1:0] m;
        m = w[SB-1:0];
        if (w[2*SB-1:SB] > m) m = w[2*SB-1:SB];
        if (w[3*SB-1:2*SB] > m) m = w[3*SB-1:2*SB];
        return m;
    endfunction

    function automatic logic [SB-1:0] sat_of(input logic [SB:0] s);
        return s[SB] ? {SB{1'b1}} : s[SB-1:0];
    endfunction

    assign idx_x = XW'(s_pixel_index);

    always_comb begin
        case (cmd.op)
            OP_CLR_ALL:  limit = IW'(CL);
            OP_FIN_CLR:  limit = IW'(LS);
            OP_FIN_MARK: limit = IW'(NP);
            OP_FIN_RANK: limit = IW'(LS);
            default:     limit = '0;
        endcase
    end

    assign walk_go = idx_reg < limit;

    assign sat_r = {1'b0, rd_sum_reg[SB-1:0]} + (SB+1)'(smp_r_reg);
    assign sat_g = {1'b0, rd_sum_reg[2*SB-1:SB]} + (SB+1)'(smp_g_reg);
    assign sat_b = {1'b0, rd_sum_reg[3*SB-1:2*SB]} + (SB+1)'(smp_b_reg);
    assign rd_lum = lum_of(rd_sum_reg);

    // Memory port steering.
    always_comb begin
        sw_en   = 1'b0;
        sw_addr = addr_reg;
        sw_data = '0;
        pw_en   = 1'b0;
        pw_addr = idx_reg[SB-1:0];
        pw_data = 1'b0;
        sr_addr = addr_reg;
        rw_en   = 1'b0;
        case (cmd.op)
            OP_CLR_ALL: begin
                sw_en   = walk_go && (idx_reg < IW'(NP));
                sw_addr = idx_reg[PAW-1:0];
                pw_en   = walk_go && (idx_reg < IW'(LS));
            end
            OP_FIN_CLR: begin
                pw_en = walk_go;
            end
            OP_ACC_WR: begin
                sw_en   = in_range_reg;
                sw_data = {sat_of(sat_b), sat_of(sat_g), sat_of(sat_r)};
            end
            OP_FIN_MARK: begin
                sr_addr = idx_reg[PAW-1:0];
                pw_en   = pipe_v_reg;
                pw_addr = rd_lum;
                pw_data = 1'b1;
            end
            OP_FIN_RANK: begin
                rw_en = pipe_v_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (sw_en) begin
            sums_mem[sw_addr] <= sw_data;
        end
        rd_sum_reg <= sums_mem[sr_addr];
    end

    always_ff @(posedge aclk) begin
        if (pw_en) begin
            pres_mem[pw_addr] <= pw_data;
        end
        pres_q_reg <= pres_mem[idx_reg[SB-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (rw_en) begin
            rank_mem[rank_wa_reg] <= cnt_reg;
        end
        rank_q_reg <= rank_mem[rd_lum];
    end

    // Walk counter, rank counter and the distinct count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            pipe_v_reg   <= 1'b0;
            cnt_reg      <= '0;
            distinct_reg <= '0;
        end else if (cmd.walk_clr) begin
            idx_reg    <= '0;
            pipe_v_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            case (cmd.op)
                OP_CLR_ALL, OP_FIN_CLR: begin
                    if (walk_go) idx_reg <= idx_reg + 1'b1;
                end
                OP_FIN_MARK: begin
                    pipe_v_reg <= walk_go;
                    if (walk_go) idx_reg <= idx_reg + 1'b1;
                end
                OP_FIN_RANK: begin
                    pipe_v_reg <= walk_go;
                    if (walk_go) idx_reg <= idx_reg + 1'b1;
                    if (pipe_v_reg) begin
                        cnt_reg      <= cnt_reg + CW'(pres_q_reg);
                        distinct_reg <= cnt_reg + CW'(pres_q_reg);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_FIN_RANK) begin
            rank_wa_reg <= idx_reg[SB-1:0];
        end
    end

    // Item capture.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg      <= s_req_type;
            addr_reg     <= idx_x[PAW-1:0];
            in_range_reg <= idx_x < XW'(NP);
            smp_r_reg    <= s_in_red;
            smp_g_reg    <= s_in_green;
            smp_b_reg    <= s_in_blue;
        end
    end

    // Read arithmetic.
    always_comb begin
        case (ch_reg)
            2'd0:    c_sel = r_reg;
            2'd1:    c_sel = g_reg;
            default: c_sel = b_reg;
        endcase
    end

    always_comb begin
        mul_start = 1'b1;
        mul_a     = '0;
        mul_b     = '0;
        case (cmd.op)
            OP_MUL_RR:  begin mul_a = OW'(r_reg);        mul_b = OW'(r_reg); end
            OP_MUL_GG:  begin mul_a = OW'(g_reg);        mul_b = OW'(g_reg); end
            OP_MUL_BB:  begin mul_a = OW'(b_reg);        mul_b = OW'(b_reg); end
            OP_MUL_NN:  begin mul_a = OW'(distinct_reg); mul_b = OW'(distinct_reg); end
            OP_MUL_BSQ: begin mul_a = n2_reg;            mul_b = sq_reg; end
            OP_MUL_CK:  begin mul_a = OW'(c_sel);        mul_b = OW'(k_reg); end
            OP_MUL_TT:  begin mul_a = t_reg;             mul_b = t_reg; end
            default:    mul_start = 1'b0;
        endcase
    end

    fartm_mul #(
        .OW(OW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .prod    (mul_p)
    );

    assign ck_trunc = mul_p[OW-1:0];
    assign cand     = p_reg + e_reg + f_reg;
    assign take     = cand <= WW'(av_reg);

    always_ff @(posedge aclk) begin
        if (mul_start) begin
            mul_dest_reg <= cmd.op;
        end
        if (mul_done) begin
            case (mul_dest_reg)
                OP_MUL_RR:  sq_reg <= mul_p[OW-1:0];
                OP_MUL_GG,
                OP_MUL_BB:  sq_reg <= sq_reg + mul_p[OW-1:0];
                OP_MUL_NN:  n2_reg <= mul_p[OW-1:0];
                OP_MUL_BSQ: bv_reg <= mul_p;
                OP_MUL_CK:  t_reg  <= (ck_trunc << 8) - ck_trunc;
                OP_MUL_TT:  av_reg <= mul_p;
                default: begin
                end
            endcase
        end
        case (cmd.op)
            OP_RD_LUM: begin
                r_reg    <= rd_sum_reg[SB-1:0];
                g_reg    <= rd_sum_reg[2*SB-1:SB];
                b_reg    <= rd_sum_reg[3*SB-1:2*SB];
                zero_reg <= !in_range_reg || (rd_sum_reg == '0) || (distinct_reg == '0);
            end
            OP_RD_K: begin
                k_reg  <= rank_q_reg;
                ch_reg <= 2'd0;
            end
            OP_Q_INIT: begin
                p_reg   <= '0;
                e_reg   <= '0;
                f_reg   <= WW'(bv_reg) << 14;
                bit_reg <= 3'd7;
                q_reg   <= '0;
            end
            // Trial of one quotient bit: the squared candidate grows by the
            // cross term and the square of the new bit, both kept pre-shifted.
            OP_Q_STEP: begin
                if (take) begin
                    p_reg          <= cand;
                    e_reg          <= (e_reg >> 1) + f_reg;
                    q_reg[bit_reg] <= 1'b1;
                end else begin
                    e_reg <= e_reg >> 1;
                end
                f_reg   <= f_reg >> 2;
                bit_reg <= bit_reg - 1'b1;
            end
            OP_Q_STORE: begin
                q_ch_reg[ch_reg] <= q_reg;
                ch_reg           <= ch_reg + 1'b1;
            end
            OP_PUBLISH: begin
                res_kind     <= (req_reg == REQ_FIN) ? KIND_FIN : KIND_PIXEL;
                res_distinct <= 16'(distinct_reg);
                if ((req_reg == REQ_FIN) || zero_reg) begin
                    res_red   <= '0;
                    res_green <= '0;
                    res_blue  <= '0;
                end else begin
                    res_red   <= q_ch_reg[0];
                    res_green <= q_ch_reg[1];
                    res_blue  <= q_ch_reg[2];
                end
            end
            default: begin
            end
        endcase
    end

    assign stat.walk_done = (idx_reg == limit) && !pipe_v_reg;
    assign stat.mul_done  = mul_done;
    assign stat.q_last    = bit_reg == 3'd0;
    assign stat.last_ch   = ch_reg == 2'd2;
    assign stat.rd_zero   = zero_reg;

endmodule
`default_nettype wire

FILE: src/fartm_ctrl.sv
// Controller state machine that sequences walks, memory accesses and read arithmetic.
`default_nettype none
module fartm_ctrl
    import fartm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_req_type,
    output logic            m_valid,
    input  wire logic       m_ready,
    output dp_cmd_t         cmd,
    input  wire dp_stat_t   stat
);
    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_FIN_CLR,
        ST_FIN_MARK,
        ST_FIN_RANK,
        ST_RD_SUM,
        ST_RD_LUM,
        ST_RD_K,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_Q_STEP,
        ST_Q_STORE,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    dp_op_t mul_op_reg, mul_op_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept, publish;

    assign accept  = (state_reg == ST_IDLE) && s_valid;
    assign publish = (state_reg == ST_RESULT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        mul_op_next  = mul_op_reg;
        cmd.load     = 1'b0;
        cmd.walk_clr = 1'b0;
        cmd.op       = OP_NOP;
        case (state_reg)
            ST_CLR: begin
                cmd.op = OP_CLR_ALL;
                if (stat.walk_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.load     = 1'b1;
                    cmd.walk_clr = 1'b1;
                    case (s_req_type)
                        REQ_ACC:  state_next = ST_ACC_RD;
                        REQ_FIN:  state_next = ST_FIN_CLR;
                        REQ_READ: state_next = ST_RD_SUM;
                        default:  state_next = ST_CLR;
                    endcase
                end
            end
            ST_ACC_RD: begin
                cmd.op     = OP_ACC_RD;
                state_next = ST_ACC_WR;
            end
            ST_ACC_WR: begin
                cmd.op     = OP_ACC_WR;
                state_next = ST_IDLE;
            end
            ST_FIN_CLR: begin
                cmd.op = OP_FIN_CLR;
                if (stat.walk_done) begin
                    cmd.walk_clr = 1'b1;
                    state_next   = ST_FIN_MARK;
                end
            end
            ST_FIN_MARK: begin
                cmd.op = OP_FIN_MARK;
                if (stat.walk_done) begin
                    cmd.walk_clr = 1'b1;
                    state_next   = ST_FIN_RANK;
                end
            end
            ST_FIN_RANK: begin
                cmd.op = OP_FIN_RANK;
                if (stat.walk_done) state_next = ST_RESULT;
            end
            ST_RD_SUM: begin
                cmd.op     = OP_RD_SUM;
                state_next = ST_RD_LUM;
            end
            ST_RD_LUM: begin
                cmd.op     = OP_RD_LUM;
                state_next = ST_RD_K;
            end
            ST_RD_K: begin
                cmd.op = OP_RD_K;
                if (stat.rd_zero) begin
                    state_next = ST_RESULT;
                end else begin
                    mul_op_next = OP_MUL_RR;
                    state_next  = ST_MUL_GO;
                end
            end
            ST_MUL_GO: begin
                cmd.op     = mul_op_reg;
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (stat.mul_done) begin
                    state_next = ST_MUL_GO;
                    case (mul_op_reg)
                        OP_MUL_RR:  mul_op_next = OP_MUL_GG;
                        OP_MUL_GG:  mul_op_next = OP_MUL_BB;
                        OP_MUL_BB:  mul_op_next = OP_MUL_NN;
                        OP_MUL_NN:  mul_op_next = OP_MUL_BSQ;
                        OP_MUL_BSQ: mul_op_next = OP_MUL_CK;
                        OP_MUL_CK:  mul_op_next = OP_MUL_TT;
                        default: begin
                            cmd.op     = OP_Q_INIT;
                            state_next = ST_Q_STEP;
                        end
                    endcase
                end
            end
            ST_Q_STEP: begin
                cmd.op = OP_Q_STEP;
                if (stat.q_last) state_next = ST_Q_STORE;
            end
            ST_Q_STORE: begin
                cmd.op = OP_Q_STORE;
                if (stat.last_ch) begin
                    state_next = ST_RESULT;
                end else begin
                    mul_op_next = OP_MUL_CK;
                    state_next  = ST_MUL_GO;
                end
            end
            ST_RESULT: begin
                if (publish) begin
                    cmd.op     = OP_PUBLISH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLR;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (publish) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            mul_op_reg  <= OP_MUL_RR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mul_op_reg  <= mul_op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

FILE: src/frame_average_rank_tone_map.sv
// Top level of the frame average rank tone map block: controller plus datapath.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid / s_ready  req_type, pixel_index, in_red/green/blue
//   m_       out        m_valid / m_ready  result_kind, out_red/green/blue,
//                                          distinct_values
//
// An accumulate reads and then writes back the sums of its pixel, and a clear
// walks max(pixels, 2^SUM_BITS) entries. A finalize walks the luminance
// bitmap, the pixels and the bitmap again. A read of a black or out of range
// pixel, or one made while the distinct count is zero, skips the arithmetic;
// otherwise the bit-serial multiplier forms eleven products in turn and a
// root search runs for each channel. After reset a clearing pass over
// max(pixels, 2^SUM_BITS) entries runs before the first item is taken. A
// finished result waits in the output register while the next item is
// taken; a result leaves that register only when m_ready.
`default_nettype none
module frame_average_rank_tone_map
    import fartm_pkg::*;
#(
    parameter int IMG_WIDTH  = 160,
    parameter int IMG_HEIGHT = 210,
    parameter int SUM_BITS   = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [15:0] s_pixel_index,
    input  wire logic [7:0]  s_in_red,
    input  wire logic [7:0]  s_in_green,
    input  wire logic [7:0]  s_in_blue,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_result_kind,
    output logic [7:0]       m_out_red,
    output logic [7:0]       m_out_green,
    output logic [7:0]       m_out_blue,
    output logic [15:0]      m_distinct_values
);
    // Command and status between the sequencer and the datapath.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    fartm_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    // The datapath holds every memory, the walk counter and the read arithmetic.
    fartm_datapath #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT),
        .SUM_BITS   (SUM_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_req_type    (s_req_type),
        .s_pixel_index (s_pixel_index),
        .s_in_red      (s_in_red),
        .s_in_green    (s_in_green),
        .s_in_blue     (s_in_blue),
        .res_kind      (m_result_kind),
        .res_red       (m_out_red),
        .res_green     (m_out_green),
        .res_blue      (m_out_blue),
        .res_distinct  (m_distinct_values)
    );

endmodule
`default_nettype wire

FILE: src/fartm_checker.sv
// Port level checker for the frame average rank tone map block and its bind.
`default_nettype none
`include "frame_average_rank_tone_map_assert.svh"
module fartm_checker
    import fartm_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_result_kind,
    input wire logic [7:0]  m_out_red,
    input wire logic [7:0]  m_out_green,
    input wire logic [7:0]  m_out_blue,
    input wire logic [15:0] m_distinct_values
);
    // A result that is not taken stays offered.
    `FARTM_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    // Its payload holds while it waits.
    `FARTM_ASSERT_NEXT(a_m_stable, aclk, aresetn, m_valid && !m_ready, $stable({m_result_kind, m_out_red, m_out_green, m_out_blue, m_distinct_values}))
    // A finalize item carries black channels.
    `FARTM_ASSERT_SAME(a_fin_black, aclk, aresetn, m_valid && (m_result_kind == KIND_FIN), (m_out_red == 8'd0) && (m_out_green == 8'd0) && (m_out_blue == 8'd0))
    // The clearing pass after reset keeps the input closed.
    `FARTM_ASSERT_NEXT_ALWAYS(a_reset_clear, aclk, !aresetn, !s_ready && !m_valid)

endmodule

bind frame_average_rank_tone_map fartm_checker u_fartm_checker (.*);
`default_nettype wire
